// ----- sv/eco_pkg.sv -----
// Shared widths, constants, types and the CORDIC arctangent table for the camera orientation block
package eco_pkg;

	localparam int MW  = 34;       // signed datapath word: Q30 values with headroom
	localparam int PW  = 2 * MW;   // product and accumulator width
	localparam int AW  = 17;       // angle register width, 1/64 degree
	localparam int VW  = 16;       // Q2.14 vector component width
	localparam int L2W = 64;       // squared length width

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int CORDIC_TABLE_LEN      = 24;

	localparam logic signed [MW-1:0] CORDIC_GAIN = MW'(652032874);
	localparam logic signed [MW-1:0] ONE_Q30     = MW'(1073741824);
	localparam logic [VW-1:0]        UNIT_Q14    = VW'(16384);

	typedef logic signed [MW-1:0] word_t;
	typedef logic signed [VW-1:0] comp_t;
	typedef word_t wvec_t [3];
	typedef comp_t cvec_t [3];

	// arctangent of 2^-i as a binary angle, full turn = 2^32
	function automatic word_t atan_entry(input logic [4:0] idx);
		word_t v;
		case (idx)
			5'd0:  v = MW'(32'h2000_0000);
			5'd1:  v = MW'(32'h12E4_051E);
			5'd2:  v = MW'(32'h09FB_385B);
			5'd3:  v = MW'(32'h0511_11D4);
			5'd4:  v = MW'(32'h028B_0D43);
			5'd5:  v = MW'(32'h0145_D7E1);
			5'd6:  v = MW'(32'h00A2_F61E);
			5'd7:  v = MW'(32'h0051_7C55);
			5'd8:  v = MW'(32'h0028_BE53);
			5'd9:  v = MW'(32'h0014_5F2F);
			5'd10: v = MW'(32'h000A_2F98);
			5'd11: v = MW'(32'h0005_17CC);
			5'd12: v = MW'(32'h0002_8BE6);
			5'd13: v = MW'(32'h0001_45F3);
			5'd14: v = MW'(32'h0000_A2FA);
			5'd15: v = MW'(32'h0000_517D);
			5'd16: v = MW'(32'h0000_28BE);
			5'd17: v = MW'(32'h0000_145F);
			5'd18: v = MW'(32'h0000_0A30);
			5'd19: v = MW'(32'h0000_0518);
			5'd20: v = MW'(32'h0000_028C);
			5'd21: v = MW'(32'h0000_0146);
			5'd22: v = MW'(32'h0000_00A3);
			5'd23: v = MW'(32'h0000_0051);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/eco_norm.sv -----
// Vector normalizer: bit-serial square root of the squared length, then one long division per component
module eco_norm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [eco_pkg::L2W-1:0]   len2,
	input  eco_pkg::wvec_t            vin,
	output logic                      done,
	output eco_pkg::cvec_t            vout
);
	import eco_pkg::*;

	localparam int QB  = 15;            // quotient bits, covers 0..16384
	localparam int CW  = $clog2(QB);
	localparam int LW  = L2W / 2;       // square root width
	localparam int RW  = MW + 14;       // |v| * 2^14 + len / 2

	typedef enum logic [2:0] {N_IDLE, N_SQRT, N_DSET, N_DIV, N_DWR} nstate_t;

	nstate_t          state_q;
	logic [L2W-1:0]   rad_q, res_q, bit_q;
	wvec_t            vec_q;
	logic [1:0]       idx_q;
	logic [CW-1:0]    cnt_q;
	logic [RW-1:0]    rem_q, dsr_q;
	logic [QB-1:0]    quo_q;
	logic             neg_q, zero_q;

	logic [L2W-1:0]   trial;
	logic [LW-1:0]    len;
	logic [MW-1:0]    mag;
	logic [QB-1:0]    qsat;

	// square root trial value, current length and magnitude of the selected component
	assign trial = res_q + bit_q;
	assign len   = res_q[LW-1:0];
	assign mag   = vec_q[idx_q][MW-1] ? MW'(-vec_q[idx_q]) : MW'(vec_q[idx_q]);
	assign qsat  = (quo_q > QB'(UNIT_Q14)) ? QB'(UNIT_Q14) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done    <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			// flag completion as the last component is written
			done <= (state_q == N_DWR) && (idx_q == 2'd2);
			case (state_q)
				N_IDLE: begin
					// latch the vector and its squared length
					if (start) begin
						rad_q   <= len2;
						res_q   <= '0;
						bit_q   <= L2W'(1) << (L2W - 2);
						vec_q   <= vin;
						idx_q   <= '0;
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					// one result bit per cycle
					if (rad_q >= trial) begin
						rad_q <= rad_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= N_DSET;
					end
				end
				N_DSET: begin
					// dividend |v| * 2^14 + len / 2, divisor aligned to the top quotient bit
					rem_q   <= (RW'(mag) << 14) + RW'(len >> 1);
					dsr_q   <= RW'(len) << (QB - 1);
					neg_q   <= vec_q[idx_q][MW-1];
					zero_q  <= (len == '0);
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					// restoring division, one quotient bit per cycle
					if (rem_q >= dsr_q) begin
						rem_q <= rem_q - dsr_q;
					end
					quo_q <= {quo_q[QB-2:0], (rem_q >= dsr_q)};
					dsr_q <= dsr_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QB - 1)) begin
						state_q <= N_DWR;
					end
				end
				N_DWR: begin
					// saturate, restore the sign (zero for a zero length), advance to the next component or return to idle
					if (zero_q) begin
						vout[idx_q] <= '0;
					end else if (neg_q) begin
						vout[idx_q] <= -VW'(qsat);
					end else begin
						vout[idx_q] <= VW'(qsat);
					end
					if (idx_q == 2'd2) begin
						state_q <= N_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= N_DSET;
					end
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/euler_camera_orientation.sv -----
// Euler-angle camera orientation: angle update, CORDIC trig, shared multiplier program, normalization
// Work per word: three CORDIC runs, 38 products on one multiplier with their write-backs,
//   and three normalizations; the 32-step square root and 15-step divisions dominate.
// A new word is taken only once the previous one has finished.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low): yaw -90 degrees, pitch and roll zero, up vector (0, 1, 0), no result pending.
module euler_camera_orientation #(
	parameter int CORDIC_ITERATIONS = eco_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [14:0] delta_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z
);
	import eco_pkg::*;

	localparam int CntW      = $clog2(CORDIC_ITERATIONS);
	localparam int FULL_TURN = 23040;
	localparam int LastStep  = 37;
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< 29;

	typedef enum logic [3:0] {
		S_IDLE, S_TPREP, S_TINIT, S_TITER, S_TEND, S_MUL, S_ACC, S_WB, S_NORM, S_DONE
	} state_t;

	typedef enum logic [1:0] {OP_YAW, OP_PITCH, OP_ROLL, OP_NONE} axis_t;

	typedef enum logic [4:0] {
		O_CYAW, O_SYAW, O_CPIT, O_SPIT, O_CROL, O_SROL, O_K0, O_K2,
		O_V0, O_V1, O_V2, O_X0, O_X1, O_X2, O_DOT, O_OMC, O_T,
		O_N0, O_N1, O_N2, O_F0, O_F1, O_F2, O_U0, O_U1, O_U2
	} opnd_t;

	typedef enum logic [1:0] {M_LOAD, M_ADD, M_SUB} amode_t;
	typedef enum logic [2:0] {W_NONE, W_RND, W_RNDADD, W_RAW, W_NORM} wb_t;
	typedef enum logic [3:0] {
		D_K0, D_K2, D_X0, D_X1, D_X2, D_DOT, D_T, D_N0, D_N1, D_N2, D_F, D_U, D_R
	} dst_t;

	typedef struct packed {
		opnd_t  a;
		opnd_t  b;
		amode_t mode;
		wb_t    wb;
		dst_t   dst;
	} uop_t;

	// product program: front, cross and dot with up, Rodrigues terms, right
	function automatic uop_t prog(input logic [5:0] step);
		uop_t u;
		u = '{a: O_K0, b: O_K0, mode: M_LOAD, wb: W_NONE, dst: D_K0};
		case (step)
			6'd0:  u = '{O_CYAW, O_CPIT, M_LOAD, W_RND,    D_K0};
			6'd1:  u = '{O_SYAW, O_CPIT, M_LOAD, W_RND,    D_K2};
			6'd2:  u = '{O_K0,   O_K0,   M_LOAD, W_NONE,   D_K0};
			6'd3:  u = '{O_SPIT, O_SPIT, M_ADD,  W_NONE,   D_K0};
			6'd4:  u = '{O_K2,   O_K2,   M_ADD,  W_NORM,   D_F};
			6'd5:  u = '{O_SPIT, O_V2,   M_LOAD, W_NONE,   D_X0};
			6'd6:  u = '{O_K2,   O_V1,   M_SUB,  W_RND,    D_X0};
			6'd7:  u = '{O_K2,   O_V0,   M_LOAD, W_NONE,   D_X1};
			6'd8:  u = '{O_K0,   O_V2,   M_SUB,  W_RND,    D_X1};
			6'd9:  u = '{O_K0,   O_V1,   M_LOAD, W_NONE,   D_X2};
			6'd10: u = '{O_SPIT, O_V0,   M_SUB,  W_RND,    D_X2};
			6'd11: u = '{O_K0,   O_V0,   M_LOAD, W_NONE,   D_DOT};
			6'd12: u = '{O_SPIT, O_V1,   M_ADD,  W_NONE,   D_DOT};
			6'd13: u = '{O_K2,   O_V2,   M_ADD,  W_RND,    D_DOT};
			6'd14: u = '{O_V0,   O_CROL, M_LOAD, W_NONE,   D_N0};
			6'd15: u = '{O_X0,   O_SROL, M_ADD,  W_RND,    D_N0};
			6'd16: u = '{O_V1,   O_CROL, M_LOAD, W_NONE,   D_N1};
			6'd17: u = '{O_X1,   O_SROL, M_ADD,  W_RND,    D_N1};
			6'd18: u = '{O_V2,   O_CROL, M_LOAD, W_NONE,   D_N2};
			6'd19: u = '{O_X2,   O_SROL, M_ADD,  W_RND,    D_N2};
			6'd20: u = '{O_K0,   O_DOT,  M_LOAD, W_RND,    D_T};
			6'd21: u = '{O_T,    O_OMC,  M_LOAD, W_RNDADD, D_N0};
			6'd22: u = '{O_SPIT, O_DOT,  M_LOAD, W_RND,    D_T};
			6'd23: u = '{O_T,    O_OMC,  M_LOAD, W_RNDADD, D_N1};
			6'd24: u = '{O_K2,   O_DOT,  M_LOAD, W_RND,    D_T};
			6'd25: u = '{O_T,    O_OMC,  M_LOAD, W_RNDADD, D_N2};
			6'd26: u = '{O_N0,   O_N0,   M_LOAD, W_NONE,   D_U};
			6'd27: u = '{O_N1,   O_N1,   M_ADD,  W_NONE,   D_U};
			6'd28: u = '{O_N2,   O_N2,   M_ADD,  W_NORM,   D_U};
			6'd29: u = '{O_F1,   O_U2,   M_LOAD, W_NONE,   D_N0};
			6'd30: u = '{O_F2,   O_U1,   M_SUB,  W_RAW,    D_N0};
			6'd31: u = '{O_F2,   O_U0,   M_LOAD, W_NONE,   D_N1};
			6'd32: u = '{O_F0,   O_U2,   M_SUB,  W_RAW,    D_N1};
			6'd33: u = '{O_F0,   O_U1,   M_LOAD, W_NONE,   D_N2};
			6'd34: u = '{O_F1,   O_U0,   M_SUB,  W_RAW,    D_N2};
			6'd35: u = '{O_N0,   O_N0,   M_LOAD, W_NONE,   D_R};
			6'd36: u = '{O_N1,   O_N1,   M_ADD,  W_NONE,   D_R};
			6'd37: u = '{O_N2,   O_N2,   M_ADD,  W_NORM,   D_R};
			default: u = '{O_K0, O_K0,   M_LOAD, W_NONE,   D_K0};
		endcase
		return u;
	endfunction

	function automatic logic signed [AW-1:0] limit_angle(input logic signed [AW-1:0] a);
		return (a > AW'(FULL_TURN) || a < -AW'(FULL_TURN)) ? '0 : a;
	endfunction

	function automatic word_t sext(input comp_t c);
		return {{(MW-VW){c[VW-1]}}, c};
	endfunction

	state_t                state_q;
	logic signed [AW-1:0]  yaw_q, pitch_q, roll_q;
	cvec_t                 up_q, f_q, r_q;
	cvec_t                 outf_q, outu_q, outr_q;
	logic                  out_valid_q;

	logic [1:0]            tsel_q;
	logic [14:0]           am_q;
	logic [8:0]            qa_q;
	logic [1:0]            quad_q;
	word_t                 xr_q, yr_q, zr_q;
	logic [CntW-1:0]       icnt_q;

	word_t                 cyaw_q, syaw_q, cpit_q, spit_q, crol_q, srol_q;
	word_t                 k0_q, k2_q, x0_q, x1_q, x2_q, dot_q, t_q, n0_q, n1_q, n2_q;

	logic [5:0]            step_q;
	logic signed [PW-1:0]  p_q, acc_q;
	logic                  nstart_q;

	uop_t                  uop;
	word_t                 opa, opb, rnd, ccos, csin, atan_i;
	logic signed [AW-1:0]  dext, ang;
	logic [14:0]           am_n, ra_w;
	logic [29:0]           qa_prod;
	logic [10:0]           t_w;
	logic [21:0]           tq_prod;
	logic [31:0]           ba, dres;
	logic [1:0]            quad_n;
	logic signed [PW-1:0]  rsum;
	logic                  ndone;
	wvec_t                 nvin;
	cvec_t                 nvout;

	assign uop = prog(step_q);

	// operand selection for the shared multiplier
	function automatic word_t opnd_val(input opnd_t s);
		word_t v;
		case (s)
			O_CYAW: v = cyaw_q;
			O_SYAW: v = syaw_q;
			O_CPIT: v = cpit_q;
			O_SPIT: v = spit_q;
			O_CROL: v = crol_q;
			O_SROL: v = srol_q;
			O_K0:   v = k0_q;
			O_K2:   v = k2_q;
			O_V0:   v = {{(MW-VW-16){up_q[0][VW-1]}}, up_q[0], 16'b0};
			O_V1:   v = {{(MW-VW-16){up_q[1][VW-1]}}, up_q[1], 16'b0};
			O_V2:   v = {{(MW-VW-16){up_q[2][VW-1]}}, up_q[2], 16'b0};
			O_X0:   v = x0_q;
			O_X1:   v = x1_q;
			O_X2:   v = x2_q;
			O_DOT:  v = dot_q;
			O_OMC:  v = ONE_Q30 - crol_q;
			O_T:    v = t_q;
			O_N0:   v = n0_q;
			O_N1:   v = n1_q;
			O_N2:   v = n2_q;
			O_F0:   v = sext(f_q[0]);
			O_F1:   v = sext(f_q[1]);
			O_F2:   v = sext(f_q[2]);
			O_U0:   v = sext(up_q[0]);
			O_U1:   v = sext(up_q[1]);
			O_U2:   v = sext(up_q[2]);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa = opnd_val(uop.a);
	assign opb = opnd_val(uop.b);

	// round to Q30: add half, floor shift
	assign rsum = acc_q + RND_HALF;
	assign rnd  = rsum[MW+29:30];

	// angle step, sign extended
	assign dext = {{(AW-15){delta_angle[14]}}, delta_angle};

	// reduce the selected angle into 0..23039 and divide by 45
	always_comb begin
		case (tsel_q)
			2'd0:    ang = yaw_q;
			2'd1:    ang = pitch_q;
			default: ang = roll_q;
		endcase
		if (ang < 0) begin
			am_n = 15'(ang + AW'(FULL_TURN));
		end else if (ang >= AW'(FULL_TURN)) begin
			am_n = 15'(ang - AW'(FULL_TURN));
		end else begin
			am_n = 15'(ang);
		end
		qa_prod = 30'(am_n) * 30'd23302;
	end

	// binary angle = 2^23 * qa + round(ra * 2^23 / 45), then split off the quadrant
	always_comb begin
		ra_w    = am_q - 15'(15'(qa_q) * 15'd45);
		t_w     = 11'(ra_w[5:0]) * 11'd23 + 11'd22;
		tq_prod = 22'(t_w) * 22'd1457;
		ba      = {qa_q, 23'b0} + 32'(ra_w[5:0]) * 32'd186413 + 32'(tq_prod[21:16]);
		quad_n  = 2'((ba + 32'h2000_0000) >> 30);
		dres    = ba - {quad_n, 30'b0};
	end

	assign atan_i = atan_entry(5'(icnt_q));

	// quadrant swap and negate
	always_comb begin
		case (quad_q)
			2'd0: begin
				ccos = xr_q;
				csin = yr_q;
			end
			2'd1: begin
				ccos = -yr_q;
				csin = xr_q;
			end
			2'd2: begin
				ccos = -xr_q;
				csin = -yr_q;
			end
			default: begin
				ccos = yr_q;
				csin = -xr_q;
			end
		endcase
	end

	// normalizer source: front takes (k0, sin pitch, k2), the others the n registers
	always_comb begin
		if (uop.dst == D_F) begin
			nvin[0] = k0_q;
			nvin[1] = spit_q;
			nvin[2] = k2_q;
		end else begin
			nvin[0] = n0_q;
			nvin[1] = n1_q;
			nvin[2] = n2_q;
		end
	end

	eco_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart_q),
		.len2   (acc_q[L2W-1:0]),
		.vin    (nvin),
		.done   (ndone),
		.vout   (nvout)
	);

	// sequencer, angle state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			yaw_q       <= -AW'(5760);
			pitch_q     <= '0;
			roll_q      <= '0;
			up_q[0]     <= '0;
			up_q[1]     <= UNIT_Q14;
			up_q[2]     <= '0;
			out_valid_q <= 1'b0;
			tsel_q      <= '0;
			icnt_q      <= '0;
			step_q      <= '0;
			nstart_q    <= 1'b0;
		end else begin
			// pulse the normalizer start as a normalize step writes back
			nstart_q <= (state_q == S_WB) && (uop.wb == W_NORM);
			// raise valid on a new result word, drop it once the word is taken
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// take a word and step the angle that it selects, if any
					if (in_valid) begin
						case (axis_t'(op))
							OP_YAW:   yaw_q   <= limit_angle(yaw_q + dext);
							OP_PITCH: pitch_q <= limit_angle(pitch_q - dext);
							OP_ROLL:  roll_q  <= limit_angle(roll_q + dext);
							default:  ;
						endcase
						tsel_q  <= '0;
						state_q <= S_TPREP;
					end
				end
				S_TPREP: begin
					am_q    <= am_n;
					qa_q    <= qa_prod[28:20];
					state_q <= S_TINIT;
				end
				S_TINIT: begin
					// load the CORDIC with the gain and the residual angle
					xr_q    <= CORDIC_GAIN;
					yr_q    <= '0;
					zr_q    <= {{(MW-32){dres[31]}}, dres};
					quad_q  <= quad_n;
					icnt_q  <= '0;
					state_q <= S_TITER;
				end
				S_TITER: begin
					// one rotation per cycle
					if (!zr_q[MW-1]) begin
						xr_q <= xr_q - (yr_q >>> icnt_q);
						yr_q <= yr_q + (xr_q >>> icnt_q);
						zr_q <= zr_q - atan_i;
					end else begin
						xr_q <= xr_q + (yr_q >>> icnt_q);
						yr_q <= yr_q - (xr_q >>> icnt_q);
						zr_q <= zr_q + atan_i;
					end
					icnt_q <= icnt_q + 1'b1;
					if (icnt_q == CntW'(CORDIC_ITERATIONS - 1)) begin
						state_q <= S_TEND;
					end
				end
				S_TEND: begin
					case (tsel_q)
						2'd0: begin
							cyaw_q <= ccos;
							syaw_q <= csin;
						end
						2'd1: begin
							cpit_q <= ccos;
							spit_q <= csin;
						end
						default: begin
							crol_q <= ccos;
							srol_q <= csin;
						end
					endcase
					if (tsel_q == 2'd2) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end else begin
						tsel_q  <= tsel_q + 1'b1;
						state_q <= S_TPREP;
					end
				end
				S_MUL: begin
					p_q     <= opa * opb;
					state_q <= S_ACC;
				end
				S_ACC: begin
					case (uop.mode)
						M_ADD:   acc_q <= acc_q + p_q;
						M_SUB:   acc_q <= acc_q - p_q;
						default: acc_q <= p_q;
					endcase
					if (uop.wb == W_NONE) begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					// write back the rounded, added or raw sum, or hand it to the normalizer
					if (uop.wb == W_NORM) begin
						state_q  <= S_NORM;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
						case (uop.dst)
							D_K0:  k0_q  <= rnd;
							D_K2:  k2_q  <= rnd;
							D_X0:  x0_q  <= rnd;
							D_X1:  x1_q  <= rnd;
							D_X2:  x2_q  <= rnd;
							D_DOT: dot_q <= rnd;
							D_T:   t_q   <= rnd;
							D_N0: begin
								if (uop.wb == W_RNDADD) begin
									n0_q <= n0_q + rnd;
								end else if (uop.wb == W_RAW) begin
									n0_q <= acc_q[MW-1:0];
								end else begin
									n0_q <= rnd;
								end
							end
							D_N1: begin
								if (uop.wb == W_RNDADD) begin
									n1_q <= n1_q + rnd;
								end else if (uop.wb == W_RAW) begin
									n1_q <= acc_q[MW-1:0];
								end else begin
									n1_q <= rnd;
								end
							end
							D_N2: begin
								if (uop.wb == W_RNDADD) begin
									n2_q <= n2_q + rnd;
								end else if (uop.wb == W_RAW) begin
									n2_q <= acc_q[MW-1:0];
								end else begin
									n2_q <= rnd;
								end
							end
							default: ;
						endcase
					end
				end
				S_NORM: begin
					// hold until the normalizer finishes
					if (ndone) begin
						case (uop.dst)
							D_F:     f_q  <= nvout;
							D_U:     up_q <= nvout;
							default: r_q  <= nvout;
						endcase
						if (step_q == 6'(LastStep)) begin
							state_q <= S_DONE;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					// move the result word to the output register once it is free
					if (!out_valid_q || out_ready) begin
						outf_q      <= f_q;
						outu_q      <= up_q;
						outr_q      <= r_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign front_x   = outf_q[0];
	assign front_y   = outf_q[1];
	assign front_z   = outf_q[2];
	assign up_x      = outu_q[0];
	assign up_y      = outu_q[1];
	assign up_z      = outu_q[2];
	assign right_x   = outr_q[0];
	assign right_y   = outr_q[1];
	assign right_z   = outr_q[2];

endmodule

// ----- sv/eco_checker.sv -----
// Port-level checks for the camera orientation block and their bind to the top level
module eco_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         op,
	input logic signed [14:0] delta_angle,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] front_x,
	input logic signed [15:0] front_y,
	input logic signed [15:0] front_z,
	input logic signed [15:0] up_x,
	input logic signed [15:0] up_y,
	input logic signed [15:0] up_z,
	input logic signed [15:0] right_x,
	input logic signed [15:0] right_y,
	input logic signed [15:0] right_z
);
	import eco_pkg::*;

	function automatic logic in_unit(input logic signed [15:0] c);
		return (c >= -16'sd16384) && (c <= 16'sd16384);
	endfunction

	logic unit_ok;

	// every shown component lies within the unit range
	assign unit_ok = in_unit(front_x) && in_unit(front_y) && in_unit(front_z)
		&& in_unit(up_x) && in_unit(up_y) && in_unit(up_z)
		&& in_unit(right_x) && in_unit(right_y) && in_unit(right_z);

	// a taken word keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous word still in work");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_ok)
		else $error("result component outside unit range");

	// a new result appears only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while block still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_x) && $stable(up_y)
			&& $stable(right_z))
		else $error("stalled result word changed");

endmodule

bind euler_camera_orientation eco_checker u_eco_checker (.*);
